// File: hdl/mtss_pkg.sv
// Shared widths, job and divider records, and sequencer states of the tile size search.
package mtss_pkg;

    localparam int DIM_W    = 16;
    localparam int BUF_W    = 25;
    localparam int STEP_W   = 13;
    localparam int EB_W     = 4;
    localparam int CNT_W    = 48;
    localparam int DVD_W    = 25;
    localparam int DSR_W    = 36;
    localparam int MUL_W    = 32;
    localparam int BASE_W   = 40;
    localparam int A_W      = 22;
    localparam int PART_W   = 49;
    localparam int CROSS_W  = 73;
    localparam int HALF_W   = 24;
    localparam int QDEPTH   = 2;

    localparam logic REG_BUFFER = 1'b0;
    localparam logic REG_STEP   = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]  dim_m;
        logic [DIM_W-1:0]  dim_n;
        logic [DIM_W-1:0]  dim_k;
        logic [EB_W-1:0]   eb;
        logic [BUF_W-1:0]  buf_bytes;
        logic [STEP_W-1:0] step;
        logic              m_lt;
        logic              n_lt;
        logic              k_lt;
        logic              empty;
    } t_job;

    typedef struct packed {
        logic             go;
        logic [DVD_W-1:0] dvd;
        logic [DSR_W-1:0] dsr;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DM, ST_DN, ST_DK, ST_T0, ST_ROW, ST_RW2,
        ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C6Q, ST_C7, ST_C8, ST_C9,
        ST_C10, ST_C11, ST_X1, ST_X2, ST_X3, ST_X4, ST_X5, ST_X6,
        ST_TAKE, ST_NXT, ST_DIV_W, ST_FIN
    } t_bstate;

endpackage

// File: hdl/mtss_in_if.sv
// Query channel: one matmul shape per transfer.
interface mtss_in_if import mtss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIM_W-1:0]  dim_m;
    logic [DIM_W-1:0]  dim_n;
    logic [DIM_W-1:0]  dim_k;
    logic [EB_W-1:0]   element_bytes;

    modport source (output valid, dim_m, dim_n, dim_k, element_bytes, input ready);
    modport sink   (input valid, dim_m, dim_n, dim_k, element_bytes, output ready);
endinterface

// File: hdl/mtss_out_if.sv
// Result channel: chosen tile per transfer.
interface mtss_out_if import mtss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [DIM_W-1:0]  tile_m;
    logic [DIM_W-1:0]  tile_n;
    logic [DIM_W-1:0]  tile_k;
    logic [BUF_W-1:0]  working_set;
    logic [CNT_W-1:0]  tile_total;

    modport source (output valid, found, tile_m, tile_n, tile_k, working_set, tile_total,
                    input ready);
    modport sink   (input valid, found, tile_m, tile_n, tile_k, working_set, tile_total,
                    output ready);
endinterface

// File: hdl/mtss_front.sv
// Front end: accepts queries, classifies them and holds them in a two-entry queue.
module mtss_front import mtss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mtss_in_if.sink           i_in,
    input  logic [BUF_W-1:0]  i_buffer_bytes,
    input  logic [STEP_W-1:0] i_tile_step,
    output t_job              o_job,
    output logic              o_job_valid,
    input  logic              i_job_pop
);
    localparam int FILL_W = $clog2(QDEPTH + 1);
    localparam int PTR_W  = $clog2(QDEPTH);

    t_job              r_slot [QDEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [FILL_W-1:0] r_fill, n_fill;
    t_job              w_job;
    logic              w_push;

    // classify the shape against the current step
    always_comb begin
        w_job.dim_m     = i_in.dim_m;
        w_job.dim_n     = i_in.dim_n;
        w_job.dim_k     = i_in.dim_k;
        w_job.eb        = i_in.element_bytes;
        w_job.buf_bytes = i_buffer_bytes;
        w_job.step      = i_tile_step;
        w_job.m_lt      = i_in.dim_m < DIM_W'(i_tile_step);
        w_job.n_lt      = i_in.dim_n < DIM_W'(i_tile_step);
        w_job.k_lt      = i_in.dim_k < DIM_W'(i_tile_step);
        w_job.empty     = (i_in.dim_m == '0) || (i_in.dim_n == '0) || (i_in.dim_k == '0)
                          || (i_tile_step == '0);
    end

    assign i_in.ready  = r_fill != FILL_W'(QDEPTH);
    assign w_push      = i_in.valid && i_in.ready;
    assign o_job_valid = r_fill != '0;
    assign o_job       = r_slot[r_rd];

    always_comb begin
        n_wr   = w_push ? r_wr + 1'b1 : r_wr;
        n_rd   = i_job_pop ? r_rd + 1'b1 : r_rd;
        n_fill = r_fill + FILL_W'(w_push) - FILL_W'(i_job_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= w_job;
        end
    end
endmodule

// File: hdl/mtss_div.sv
// Restoring divider, one quotient bit per cycle.
module mtss_div import mtss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int DCNT_W = $clog2(DVD_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [DSR_W-1:0]  r_rem, n_rem;
    logic [DSR_W-1:0]  r_dsr, n_dsr;
    logic [DVD_W-1:0]  r_quo, n_quo;
    logic [DSR_W:0]    w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_quo  = r_quo;
        if (i_req.go) begin
            n_busy = 1'b1;
            n_cnt  = DCNT_W'(DVD_W);
            n_rem  = '0;
            n_dsr  = i_req.dsr;
            n_quo  = i_req.dvd;
        end else if (r_busy) begin
            n_rem = w_fit ? DSR_W'(w_trial - {1'b0, r_dsr}) : w_trial[DSR_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], w_fit};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_quo <= n_quo;
    end
endmodule

// File: hdl/mtss_back.sv
// Back end: walks the tile candidates of one query and keeps the best one.
module mtss_back import mtss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_job     i_job,
    input  logic     i_job_valid,
    output logic     o_job_pop,
    output t_div_req o_div_req,
    input  t_div_rsp i_div_rsp,
    mtss_out_if.source o_out
);
    t_bstate r_state, n_state;
    t_bstate r_ret, n_ret;
    t_job    r_job, n_job;

    logic [DVD_W-1:0]   r_quo, n_quo;
    logic [DIM_W-1:0]   r_ri, n_ri, r_ci, n_ci, r_cn, n_cn, r_ck, n_ck;
    logic [DIM_W-1:0]   r_tm, n_tm, r_tn, n_tn, r_tk, n_tk, r_q, n_q;
    logic [DIM_W-1:0]   r_cdm, n_cdm, r_cdn, n_cdn, r_cdk, n_cdk;
    logic [MUL_W-1:0]   r_tmtn, n_tmtn;
    logic [BASE_W-1:0]  r_base, n_base, r_ws, n_ws;
    logic [A_W-1:0]     r_a, n_a;
    logic [CNT_W-1:0]   r_macs, n_macs, r_cnt, n_cnt;
    logic [PART_W-1:0]  r_ph1, n_ph1, r_pl1, n_pl1, r_ph2, n_ph2, r_pl2, n_pl2;
    logic [CROSS_W-1:0] r_lhs, n_lhs, r_rhs, n_rhs;

    logic               r_bvalid, n_bvalid;
    logic [DIM_W-1:0]   r_btm, n_btm, r_btn, n_btn, r_btk, n_btk;
    logic [BUF_W-1:0]   r_bbytes, n_bbytes;
    logic [CNT_W-1:0]   r_bcnt, n_bcnt, r_bmacs, n_bmacs;

    logic               r_ovalid, n_ovalid;
    logic               r_ofound, n_ofound;
    logic [DIM_W-1:0]   r_otm, n_otm, r_otn, n_otn, r_otk, n_otk;
    logic [BUF_W-1:0]   r_ows, n_ows;
    logic [CNT_W-1:0]   r_otot, n_otot;

    logic [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic [2*MUL_W-1:0] w_prod;
    logic [DIM_W-1:0]   w_s, w_quo_fix, w_q_clamp;
    logic               w_base_over, w_ws_over, w_take, w_out_free;

    assign w_prod      = (2*MUL_W)'(w_mul_a) * (2*MUL_W)'(w_mul_b);
    assign w_s         = DIM_W'(r_job.step);
    assign w_quo_fix   = (r_quo == '0) ? DIM_W'(1) : r_quo[DIM_W-1:0];
    assign w_q_clamp   = (r_quo > DVD_W'(r_ck)) ? r_ck : r_quo[DIM_W-1:0];
    assign w_base_over = r_base > BASE_W'(r_job.buf_bytes);
    assign w_ws_over   = r_ws > BASE_W'(r_job.buf_bytes);
    assign w_out_free  = !r_ovalid || o_out.ready;
    // higher intensity, then fewer tiles, then more MACs
    assign w_take      = (r_lhs > r_rhs) || ((r_lhs == r_rhs) &&
                         ((r_cnt != r_bcnt) ? (r_cnt < r_bcnt) : (r_macs > r_bmacs)));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_job_valid) n_state = i_job.empty ? ST_FIN : ST_DM;
            ST_DM:    n_state = ST_DIV_W;
            ST_DN:    n_state = ST_DIV_W;
            ST_DK:    n_state = ST_DIV_W;
            ST_T0:    n_state = ST_ROW;
            ST_ROW:   n_state = ST_DIV_W;
            ST_RW2:   n_state = ST_C1;
            ST_C1:    n_state = ST_C2;
            ST_C2:    n_state = ST_C3;
            ST_C3:    n_state = ST_C4;
            ST_C4:    n_state = w_base_over ? ST_NXT : ST_C5;
            ST_C5: begin
                if (r_job.k_lt) n_state = ST_C7;
                else if (r_a == '0) n_state = ST_C6Q;
                else n_state = ST_DIV_W;
            end
            ST_C6:    n_state = ST_C6Q;
            ST_C6Q:   n_state = (r_q == '0) ? ST_NXT : ST_C7;
            ST_C7:    n_state = ST_C8;
            ST_C8:    n_state = w_ws_over ? ST_NXT : ST_DIV_W;
            ST_C9:    n_state = ST_DIV_W;
            ST_C10:   n_state = ST_C11;
            ST_C11:   n_state = r_bvalid ? ST_X1 : ST_TAKE;
            ST_X1:    n_state = ST_X2;
            ST_X2:    n_state = ST_X3;
            ST_X3:    n_state = ST_X4;
            ST_X4:    n_state = ST_X5;
            ST_X5:    n_state = ST_X6;
            ST_X6:    n_state = w_take ? ST_TAKE : ST_NXT;
            ST_TAKE:  n_state = ST_NXT;
            ST_NXT: begin
                if (r_ci != DIM_W'(1)) n_state = ST_C1;
                else if (r_ri != DIM_W'(1)) n_state = ST_ROW;
                else n_state = ST_FIN;
            end
            ST_DIV_W: if (i_div_rsp.done) n_state = r_ret;
            ST_FIN:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_ret = r_ret;   n_job = r_job;   n_quo = r_quo;
        n_ri = r_ri;     n_ci = r_ci;     n_cn = r_cn;     n_ck = r_ck;
        n_tm = r_tm;     n_tn = r_tn;     n_tk = r_tk;     n_q = r_q;
        n_cdm = r_cdm;   n_cdn = r_cdn;   n_cdk = r_cdk;   n_tmtn = r_tmtn;
        n_base = r_base; n_ws = r_ws;     n_a = r_a;
        n_macs = r_macs; n_cnt = r_cnt;
        n_ph1 = r_ph1;   n_pl1 = r_pl1;   n_ph2 = r_ph2;   n_pl2 = r_pl2;
        n_lhs = r_lhs;   n_rhs = r_rhs;
        n_bvalid = r_bvalid; n_btm = r_btm; n_btn = r_btn; n_btk = r_btk;
        n_bbytes = r_bbytes; n_bcnt = r_bcnt; n_bmacs = r_bmacs;
        n_ovalid = r_ovalid && !o_out.ready;
        n_ofound = r_ofound; n_otm = r_otm; n_otn = r_otn; n_otk = r_otk;
        n_ows = r_ows;   n_otot = r_otot;
        w_mul_a = '0;    w_mul_b = '0;
        o_div_req = '0;  o_job_pop = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_bvalid  = 1'b0;
                    n_btm = '0; n_btn = '0; n_btk = '0;
                    n_bbytes = '0; n_bcnt = '0; n_bmacs = '0;
                end
            end
            ST_DM: begin
                o_div_req = '{go: 1'b1, dvd: DVD_W'(r_job.dim_m), dsr: DSR_W'(r_job.step)};
                n_ret = ST_DN;
            end
            ST_DN: begin
                n_ri = w_quo_fix;
                o_div_req = '{go: 1'b1, dvd: DVD_W'(r_job.dim_n), dsr: DSR_W'(r_job.step)};
                n_ret = ST_DK;
            end
            ST_DK: begin
                n_cn = w_quo_fix;
                o_div_req = '{go: 1'b1, dvd: DVD_W'(r_job.dim_k), dsr: DSR_W'(r_job.step)};
                n_ret = ST_T0;
            end
            ST_T0: begin
                n_ck = r_quo[DIM_W-1:0];
                w_mul_a = MUL_W'(r_ri);
                w_mul_b = MUL_W'(w_s);
                n_tm = r_job.m_lt ? r_job.dim_m : w_prod[DIM_W-1:0];
            end
            ST_ROW: begin
                w_mul_a = MUL_W'(r_cn);
                w_mul_b = MUL_W'(w_s);
                n_tn = r_job.n_lt ? r_job.dim_n : w_prod[DIM_W-1:0];
                n_ci = r_cn;
                o_div_req = '{go: 1'b1,
                              dvd: DVD_W'((DIM_W+1)'(r_job.dim_m) + (DIM_W+1)'(r_tm) - 1'b1),
                              dsr: DSR_W'(r_tm)};
                n_ret = ST_RW2;
            end
            ST_RW2: n_cdm = r_quo[DIM_W-1:0];
            ST_C1: begin
                w_mul_a = MUL_W'(r_tm);
                w_mul_b = MUL_W'(r_tn);
                n_tmtn  = w_prod[MUL_W-1:0];
            end
            ST_C2: begin
                w_mul_a = r_tmtn;
                w_mul_b = MUL_W'((EB_W+1)'(4) + (EB_W+1)'(r_job.eb));
                n_base  = w_prod[BASE_W-1:0];
            end
            ST_C3: begin
                w_mul_a = MUL_W'(r_tn);
                w_mul_b = MUL_W'(r_job.eb);
                n_base  = r_base + w_prod[BASE_W-1:0];
            end
            ST_C4: begin
                w_mul_a = MUL_W'(r_job.eb);
                w_mul_b = MUL_W'((DIM_W+1)'(r_tm) + (DIM_W+1)'(r_tn));
                n_a     = {w_prod[A_W-2:0], 1'b0};
            end
            ST_C5: begin
                if (r_job.k_lt) begin
                    n_tk = r_job.dim_k;
                end else if (r_a == '0) begin
                    n_q = r_ck;
                end else begin
                    w_mul_a = MUL_W'(r_a);
                    w_mul_b = MUL_W'(w_s);
                    o_div_req = '{go: 1'b1,
                                  dvd: r_job.buf_bytes - r_base[BUF_W-1:0],
                                  dsr: w_prod[DSR_W-1:0]};
                    n_ret = ST_C6;
                end
            end
            ST_C6:  n_q = w_q_clamp;
            ST_C6Q: begin
                w_mul_a = MUL_W'(r_q);
                w_mul_b = MUL_W'(w_s);
                n_tk    = w_prod[DIM_W-1:0];
            end
            ST_C7: begin
                w_mul_a = MUL_W'(r_a);
                w_mul_b = MUL_W'(r_tk);
                n_ws    = r_base + w_prod[BASE_W-1:0];
            end
            ST_C8: begin
                w_mul_a = r_tmtn;
                w_mul_b = MUL_W'(r_tk);
                n_macs  = w_prod[CNT_W-1:0];
                o_div_req = '{go: 1'b1,
                              dvd: DVD_W'((DIM_W+1)'(r_job.dim_n) + (DIM_W+1)'(r_tn) - 1'b1),
                              dsr: DSR_W'(r_tn)};
                n_ret = ST_C9;
            end
            ST_C9: begin
                n_cdn = r_quo[DIM_W-1:0];
                o_div_req = '{go: 1'b1,
                              dvd: DVD_W'((DIM_W+1)'(r_job.dim_k) + (DIM_W+1)'(r_tk) - 1'b1),
                              dsr: DSR_W'(r_tk)};
                n_ret = ST_C10;
            end
            ST_C10: begin
                n_cdk   = r_quo[DIM_W-1:0];
                w_mul_a = MUL_W'(r_cdm);
                w_mul_b = MUL_W'(r_cdn);
                n_cnt   = CNT_W'(w_prod[MUL_W-1:0]);
            end
            ST_C11: begin
                w_mul_a = r_cnt[MUL_W-1:0];
                w_mul_b = MUL_W'(r_cdk);
                n_cnt   = w_prod[CNT_W-1:0];
            end
            // cross products split at bit 24 to keep each multiply narrow
            ST_X1: begin
                w_mul_a = MUL_W'(r_macs[CNT_W-1:HALF_W]);
                w_mul_b = MUL_W'(r_bbytes);
                n_ph1   = w_prod[PART_W-1:0];
            end
            ST_X2: begin
                w_mul_a = MUL_W'(r_macs[HALF_W-1:0]);
                w_mul_b = MUL_W'(r_bbytes);
                n_pl1   = w_prod[PART_W-1:0];
            end
            ST_X3: begin
                w_mul_a = MUL_W'(r_bmacs[CNT_W-1:HALF_W]);
                w_mul_b = MUL_W'(r_ws[BUF_W-1:0]);
                n_ph2   = w_prod[PART_W-1:0];
            end
            ST_X4: begin
                w_mul_a = MUL_W'(r_bmacs[HALF_W-1:0]);
                w_mul_b = MUL_W'(r_ws[BUF_W-1:0]);
                n_pl2   = w_prod[PART_W-1:0];
            end
            ST_X5: begin
                n_lhs = {r_ph1, HALF_W'(0)} + CROSS_W'(r_pl1);
                n_rhs = {r_ph2, HALF_W'(0)} + CROSS_W'(r_pl2);
            end
            ST_TAKE: begin
                n_bvalid = 1'b1;
                n_btm = r_tm; n_btn = r_tn; n_btk = r_tk;
                n_bbytes = r_ws[BUF_W-1:0];
                n_bcnt = r_cnt; n_bmacs = r_macs;
            end
            ST_NXT: begin
                if (r_ci != DIM_W'(1)) begin
                    n_tn = r_tn - w_s;
                    n_ci = r_ci - 1'b1;
                end else if (r_ri != DIM_W'(1)) begin
                    n_tm = r_tm - w_s;
                    n_ri = r_ri - 1'b1;
                end
            end
            ST_DIV_W: if (i_div_rsp.done) n_quo = i_div_rsp.quo;
            ST_FIN: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ofound = r_bvalid;
                    n_otm = r_btm; n_otn = r_btn; n_otk = r_btk;
                    n_ows = r_bbytes; n_otot = r_bcnt;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.found       = r_ofound;
    assign o_out.tile_m      = r_otm;
    assign o_out.tile_n      = r_otn;
    assign o_out.tile_k      = r_otk;
    assign o_out.working_set = r_ows;
    assign o_out.tile_total  = r_otot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_bvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_bvalid <= n_bvalid;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;   r_quo <= n_quo;
        r_ri <= n_ri;     r_ci <= n_ci;     r_cn <= n_cn;     r_ck <= n_ck;
        r_tm <= n_tm;     r_tn <= n_tn;     r_tk <= n_tk;     r_q <= n_q;
        r_cdm <= n_cdm;   r_cdn <= n_cdn;   r_cdk <= n_cdk;   r_tmtn <= n_tmtn;
        r_base <= n_base; r_ws <= n_ws;     r_a <= n_a;
        r_macs <= n_macs; r_cnt <= n_cnt;
        r_ph1 <= n_ph1;   r_pl1 <= n_pl1;   r_ph2 <= n_ph2;   r_pl2 <= n_pl2;
        r_lhs <= n_lhs;   r_rhs <= n_rhs;
        r_btm <= n_btm;   r_btn <= n_btn;   r_btk <= n_btk;
        r_bbytes <= n_bbytes; r_bcnt <= n_bcnt; r_bmacs <= n_bmacs;
        r_ofound <= n_ofound; r_otm <= n_otm; r_otn <= n_otn; r_otk <= n_otk;
        r_ows <= n_ows;   r_otot <= n_otot;
    end

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_ofound |-> r_otm == '0 && r_otn == '0 && r_otk == '0 && r_otot == '0)
        else $error("empty result carries a nonzero tile");

    a_found_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_ofound |-> r_ows <= r_job.buf_bytes && r_otm != '0 && r_otk != '0)
        else $error("chosen tile does not fit the buffer");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FIN && w_out_free |=> r_ovalid && r_state == ST_IDLE)
        else $error("finished query not presented");
endmodule

// File: hdl/matmul_tile_size_search_top.sv
// Top level of the matmul tile size search: config registers, front end, divider, back end.
//
// Usage: a query (dim_m, dim_n, dim_k, element_bytes) is a transfer on i_in; each query
// returns exactly one result transfer on o_out (found, tile, working set, tile count), in
// order. buffer_bytes (address 0) and tile_step (address 4) are written over the APB port
// while the block is idle; pready is always high and reads return the register values.
// The front end takes queries into a two-entry queue, so up to two queries may wait while
// one is searched. The back end walks every (tm, tn) pair once and sizes tk from the free
// buffer. A pair whose base does not fit is skipped; when K is below the step, tk is the
// whole K and takes no division. A query with a zero dimension or zero step skips the
// search and returns found low. The shared radix-2 divider serves the candidate counts,
// the tile counts and tk, and the single 32x32 multiplier is stepped through the candidate
// arithmetic. Reset empties the queue, clears the search state and the output valid flag
// and loads buffer_bytes = 262144 and tile_step = 16. A stalled receiver holds the finished
// result in the output register; the search of the next query stops before loading its own.
module matmul_tile_size_search_top import mtss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtss_in_if.sink     i_in,
    mtss_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [BUF_W-1:0]  r_buffer_bytes;
    logic [STEP_W-1:0] r_tile_step;
    logic              w_wr;
    t_job              w_job;
    logic              w_job_valid, w_job_pop;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_STEP) ? 32'(r_tile_step) : 32'(r_buffer_bytes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_bytes <= BUF_W'(262144);
            r_tile_step    <= STEP_W'(16);
        end else if (w_wr) begin
            if (paddr[2] == REG_BUFFER) r_buffer_bytes <= pwdata[BUF_W-1:0];
            else                        r_tile_step    <= pwdata[STEP_W-1:0];
        end
    end

    mtss_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_buffer_bytes (r_buffer_bytes),
        .i_tile_step    (r_tile_step),
        .o_job          (w_job),
        .o_job_valid    (w_job_valid),
        .i_job_pop      (w_job_pop)
    );

    mtss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    mtss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_out       (o_out)
    );
endmodule
